[rtl/dso_pkg.sv]
// shared types and constants of the disk seek order scheduler
// no dependencies; imported by every module of the block
package dso_pkg;

  // sizes
  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_BITS   = 12;
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int SUM_W        = 17;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int KEY_W        = 1 + ((TRACK_BITS > IDX_W) ? TRACK_BITS : IDX_W);

  // queue depths
  localparam int REQ_DEPTH = 4;
  localparam int REQ_PTR_W = $clog2(REQ_DEPTH);
  localparam int RES_DEPTH = 2;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TRACK_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_TRACK = 1'b0,
    CFG_ORDER_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ARRIVAL    = 2'd0,
    MODE_DOWN_SWEEP = 2'd1,
    MODE_LOOK       = 2'd2,
    MODE_CLOOK      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_SCAN,
    BK_EMIT
  } back_state_e;

  // input word
  typedef struct packed {
    logic [TRACK_BITS-1:0] track;
    logic                  last;
  } req_item_t;

  // result word
  typedef struct packed {
    logic [TRACK_BITS-1:0] from_track;
    logic [TRACK_BITS-1:0] to_track;
    logic [TRACK_BITS-1:0] distance;
    logic [SUM_W-1:0]      total_seek;
    logic                  end_of_run;
  } res_item_t;

  // request after classification against the head position
  typedef struct packed {
    logic      upper;
    req_item_t item;
  } cls_req_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic     valid;
    cls_req_t data;
  } req_q_t;

endpackage

[rtl/dso_front.sv]
// front end: classifies each request against the head and queues it
// depends on dso_pkg
module dso_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  dso_pkg::req_item_t              req_i,
  input  logic [dso_pkg::TRACK_BITS-1:0]  head_track_i,
  input  logic                            req_pop_i,
  output dso_pkg::req_q_t                 req_q_o
);
  import dso_pkg::*;

  cls_req_t             buf_q [REQ_DEPTH];
  logic [REQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [REQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [REQ_PTR_W:0]   cnt_q, cnt_d;
  logic                 push_ok, pop_ok;
  cls_req_t             cls;

  // classify: strictly above head is upper, equal counts as lower
  always_comb begin
    cls.upper = req_i.track > head_track_i;
    cls.item  = req_i;
  end

  assign full_o  = cnt_q == (REQ_PTR_W+1)'(REQ_DEPTH);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = req_pop_i && (cnt_q != '0);

  assign req_q_o.valid = cnt_q != '0;
  assign req_q_o.data  = buf_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + REQ_PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_q + REQ_PTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + (REQ_PTR_W+1)'(1);
    end else if (!push_ok && pop_ok) begin
      cnt_d = cnt_q - (REQ_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      buf_q[wr_ptr_q] <= cls;
    end
  end

endmodule

[rtl/dso_res_fifo.sv]
// result queue between the back end and the output side
// depends on dso_pkg
module dso_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  dso_pkg::res_item_t data_i,
  input  logic               pop_i,
  output logic               empty_o,
  output dso_pkg::res_item_t data_o
);
  import dso_pkg::*;

  res_item_t            buf_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_PTR_W:0]   cnt_q, cnt_d;
  logic                 push_ok, pop_ok;

  assign full_o  = cnt_q == (RES_PTR_W+1)'(RES_DEPTH);
  assign empty_o = cnt_q == '0;
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = buf_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + RES_PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_q + RES_PTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + (RES_PTR_W+1)'(1);
    end else if (!push_ok && pop_ok) begin
      cnt_d = cnt_q - (RES_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/dso_back.sv]
// back end: request store, selection scan for the next track, seek arithmetic
// depends on dso_pkg
module dso_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [dso_pkg::TRACK_BITS-1:0]  head_track_i,
  input  dso_pkg::mode_e                  order_mode_i,
  input  dso_pkg::req_q_t                 req_q_i,
  output logic                            req_pop_o,
  output logic                            res_push_o,
  output dso_pkg::res_item_t              res_o,
  input  logic                            res_full_i
);
  import dso_pkg::*;

  typedef struct packed {
    logic                  upper;
    logic [TRACK_BITS-1:0] track;
  } entry_t;

  // request store
  entry_t                mem [MAX_REQUESTS];
  entry_t                rd_data_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  entry_t                mem_wdata;
  logic [IDX_W-1:0]      rd_addr;

  // control
  back_state_e           state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      scan_q, scan_d;
  logic [CNT_W-1:0]      served_q, served_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [MAX_REQUESTS-1:0] used_q, used_d;
  logic                  best_vld_q, best_vld_d;

  // datapath
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [KEY_W-1:0]      best_key_q, best_key_d;
  logic [TRACK_BITS-1:0] best_track_q, best_track_d;
  logic [TRACK_BITS-1:0] pos_q, pos_d;
  logic [SUM_W-1:0]      sum_q, sum_d;

  logic [KEY_W-1:0]      cand_key;
  logic [TRACK_BITS-1:0] inv_track;
  logic [TRACK_BITS-1:0] seek_len;
  logic [SUM_W:0]        sum_wide;
  logic [SUM_W-1:0]      sum_next;
  logic                  eor;

  // service key: the smallest unused key is served next
  always_comb begin
    inv_track = ~rd_data_q.track;
    unique case (order_mode_i)
      MODE_ARRIVAL: begin
        cand_key = {1'b0, (KEY_W-1)'(rd_idx_q)};
      end
      MODE_DOWN_SWEEP: begin
        cand_key = rd_data_q.upper ? {1'b1, (KEY_W-1)'(rd_data_q.track)}
                                   : {1'b0, (KEY_W-1)'(inv_track)};
      end
      MODE_LOOK: begin
        cand_key = rd_data_q.upper ? {1'b0, (KEY_W-1)'(rd_data_q.track)}
                                   : {1'b1, (KEY_W-1)'(inv_track)};
      end
      MODE_CLOOK: begin
        cand_key = {!rd_data_q.upper, (KEY_W-1)'(rd_data_q.track)};
      end
      default: begin
        cand_key = '0;
      end
    endcase
  end

  // seek distance and saturating running total
  always_comb begin
    seek_len = (best_track_q > pos_q) ? (best_track_q - pos_q) : (pos_q - best_track_q);
    sum_wide = {1'b0, sum_q} + (SUM_W+1)'(seek_len);
    sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    eor      = (served_q + CNT_W'(1)) == cnt_q;
  end

  always_comb begin
    res_o.from_track = pos_q;
    res_o.to_track   = best_track_q;
    res_o.distance   = seek_len;
    res_o.total_seek = sum_next;
    res_o.end_of_run = eor;
  end

  // sequencer: load, scan for the next track, emit one move
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    scan_d       = scan_q;
    served_d     = served_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    used_d       = used_q;
    best_vld_d   = best_vld_q;
    best_idx_d   = best_idx_q;
    best_key_d   = best_key_q;
    best_track_d = best_track_q;
    pos_d        = pos_q;
    sum_d        = sum_q;
    req_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q[IDX_W-1:0];
    mem_wdata    = {req_q_i.data.upper, req_q_i.data.item.track};
    rd_addr      = scan_q[IDX_W-1:0];
    unique case (state_q)
      BK_LOAD: begin
        if (req_q_i.valid) begin
          req_pop_o = 1'b1;
          // a full store drops the request
          if (cnt_q < CNT_W'(MAX_REQUESTS)) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
          end
          if (req_q_i.data.item.last) begin
            state_d    = BK_SCAN;
            scan_d     = '0;
            served_d   = '0;
            used_d     = '0;
            best_vld_d = 1'b0;
            pos_d      = head_track_i;
            sum_d      = '0;
          end
        end
      end
      BK_SCAN: begin
        // issue one store read per cycle
        if (scan_q < cnt_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + CNT_W'(1);
        end
        // compare returned entry with the best so far
        if (rd_vld_q && !used_q[rd_idx_q] && (!best_vld_q || (cand_key < best_key_q))) begin
          best_vld_d   = 1'b1;
          best_idx_d   = rd_idx_q;
          best_key_d   = cand_key;
          best_track_d = rd_data_q.track;
        end
        if ((scan_q == cnt_q) && !rd_vld_q) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!res_full_i) begin
          res_push_o         = 1'b1;
          used_d[best_idx_q] = 1'b1;
          pos_d              = best_track_q;
          sum_d              = sum_next;
          served_d           = served_q + CNT_W'(1);
          if (eor) begin
            state_d = BK_LOAD;
            cnt_d   = '0;
          end else begin
            state_d    = BK_SCAN;
            scan_d     = '0;
            best_vld_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = BK_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_LOAD;
      cnt_q      <= '0;
      scan_q     <= '0;
      served_q   <= '0;
      rd_vld_q   <= 1'b0;
      used_q     <= '0;
      best_vld_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      scan_q     <= scan_d;
      served_q   <= served_d;
      rd_vld_q   <= rd_vld_d;
      used_q     <= used_d;
      best_vld_q <= best_vld_d;
      sum_q      <= sum_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    best_idx_q   <= best_idx_d;
    best_key_q   <= best_key_d;
    best_track_q <= best_track_d;
    pos_q        <= pos_d;
  end

  // store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

endmodule

[rtl/disk_seek_order_scheduler_unit.sv]
// loading: one request per cycle while the back end loads and the front queue is
//   not full; a word is registered in the front queue before the back end pops it
// ordering: each move scans all n held requests through the single store read port
// results appear through a two-word queue; the front queue takes up to four
//   requests while the back end works on a batch
// reset clears queues, counters, sequencer and config; the store needs no clearing
module disk_seek_order_scheduler_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  dso_pkg::req_item_t              req_i,
  output logic                            empty,
  input  logic                            pop,
  output dso_pkg::res_item_t              res_o,
  input  logic                            cfg_we_i,
  input  logic [dso_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dso_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import dso_pkg::*;

  logic [TRACK_BITS-1:0] head_track_q;
  mode_e                 order_mode_q;
  req_q_t                req_q;
  logic                  req_pop;
  logic                  res_push;
  logic                  res_full;
  res_item_t             res_word;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_track_q <= '0;
      order_mode_q <= MODE_ARRIVAL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEAD_TRACK: head_track_q <= cfg_wdata_i[TRACK_BITS-1:0];
        CFG_ORDER_MODE: order_mode_q <= mode_e'(cfg_wdata_i[1:0]);
        default: begin
        end
      endcase
    end
  end

  dso_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .req_i        (req_i),
    .head_track_i (head_track_q),
    .req_pop_i    (req_pop),
    .req_q_o      (req_q)
  );

  dso_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_track_i (head_track_q),
    .order_mode_i (order_mode_q),
    .req_q_i      (req_q),
    .req_pop_o    (req_pop),
    .res_push_o   (res_push),
    .res_o        (res_word),
    .res_full_i   (res_full)
  );

  dso_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_word),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_o)
  );

  // last popped word, for the checks below
  logic                  chk_eor_q;
  logic [TRACK_BITS-1:0] chk_to_q;
  logic [SUM_W-1:0]      chk_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_eor_q <= 1'b1;
    end else if (pop && !empty) begin
      chk_eor_q <= res_o.end_of_run;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !empty) begin
      chk_to_q    <= res_o.to_track;
      chk_total_q <= res_o.total_seek;
    end
  end

  // distance matches the two tracks of the move
  a_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.distance == ((res_o.to_track > res_o.from_track)
                                   ? (res_o.to_track - res_o.from_track)
                                   : (res_o.from_track - res_o.to_track))))
    else $error("distance does not match from and to tracks");

  // moves of a batch chain head position and running total
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !chk_eor_q) |->
      ((res_o.from_track == chk_to_q) &&
       (res_o.total_seek == (chk_total_q + SUM_W'(res_o.distance)))))
    else $error("move does not continue the previous one");

  // first move of a batch restarts the total
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && chk_eor_q) |-> (res_o.total_seek == SUM_W'(res_o.distance)))
    else $error("total not restarted at batch start");

endmodule

[verif/dso_seek_monitor.sv]
// result checker for the disk seek order scheduler: watches the request, result and
// register channels, computes the expected moves and compares them word by word
// depends on dso_pkg
`timescale 1ns / 1ps
module dso_seek_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  dso_pkg::req_item_t             req_i,
  input  logic                           empty,
  input  logic                           pop,
  input  dso_pkg::res_item_t             res_o,
  input  logic                           cfg_we_i,
  input  logic [dso_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dso_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import dso_pkg::*;

  typedef logic [TRACK_BITS-1:0] track_t;
  typedef track_t track_list_t[$];

  // shadow of the register file and of the batch being loaded
  track_t      head_pos;
  mode_e       sweep_mode;
  track_list_t batch_tracks;
  res_item_t   moves_due[$];
  res_item_t   due_move;

  // insertion sort of a track list
  function automatic track_list_t sorted_tracks(track_list_t src, bit descending);
    track_list_t r;
    track_t      tmp;
    r = src;
    for (int a = 1; a < r.size(); a++) begin
      for (int b = a; b > 0; b--) begin
        if (descending ? (r[b-1] >= r[b]) : (r[b-1] <= r[b])) break;
        tmp    = r[b];
        r[b]   = r[b-1];
        r[b-1] = tmp;
      end
    end
    return r;
  endfunction

  // service order of the closed batch and the moves it produces
  function automatic void plan_moves();
    track_list_t lower, upper, first_leg, second_leg, order;
    track_t      pos, move_len;
    int          sum;
    res_item_t   mv;
    // a request equal to the head goes with the lower side
    foreach (batch_tracks[k]) begin
      if (batch_tracks[k] > head_pos) upper.push_back(batch_tracks[k]);
      else lower.push_back(batch_tracks[k]);
    end
    case (sweep_mode)
      MODE_ARRIVAL: begin
        first_leg = batch_tracks;
      end
      MODE_DOWN_SWEEP: begin
        first_leg  = sorted_tracks(lower, 1'b1);
        second_leg = sorted_tracks(upper, 1'b0);
      end
      MODE_LOOK: begin
        first_leg  = sorted_tracks(upper, 1'b0);
        second_leg = sorted_tracks(lower, 1'b1);
      end
      default: begin
        first_leg  = sorted_tracks(upper, 1'b0);
        second_leg = sorted_tracks(lower, 1'b0);
      end
    endcase
    order = first_leg;
    foreach (second_leg[k]) order.push_back(second_leg[k]);
    // walk the order from the head, running total saturates
    pos = head_pos;
    sum = 0;
    foreach (order[k]) begin
      move_len = (order[k] > pos) ? order[k] - pos : pos - order[k];
      sum  = sum + int'(move_len);
      if (sum > int'(SUM_MAX)) sum = int'(SUM_MAX);
      mv.from_track = pos;
      mv.to_track   = order[k];
      mv.distance   = move_len;
      mv.total_seek = sum[SUM_W-1:0];
      mv.end_of_run = (k == order.size() - 1);
      moves_due.push_back(mv);
      pos = order[k];
    end
    batch_tracks.delete();
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_pos   = '0;
      sweep_mode = MODE_ARRIVAL;
      batch_tracks.delete();
      moves_due.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAD_TRACK) head_pos = cfg_wdata_i[TRACK_BITS-1:0];
        else sweep_mode = mode_e'(cfg_wdata_i[1:0]);
      end
      // result words against the oldest expected move
      if (pop && !empty) begin
        if (moves_due.size() == 0) begin
          $error("result word with no move expected: from %0d to %0d",
                 res_o.from_track, res_o.to_track);
          fail_count_o++;
        end else begin
          due_move = moves_due.pop_front();
          check_field("from_track", due_move.from_track, res_o.from_track);
          check_field("to_track", due_move.to_track, res_o.to_track);
          check_field("distance", due_move.distance, res_o.distance);
          check_field("total_seek", due_move.total_seek, res_o.total_seek);
          check_field("end_of_run", due_move.end_of_run, res_o.end_of_run);
        end
      end
      // request words; a full store drops the request but still honors last
      if (push && !full) begin
        if (batch_tracks.size() < MAX_REQUESTS) batch_tracks.push_back(req_i.track);
        if (req_i.last) plan_moves();
      end
    end
    pending_o = moves_due.size();
  end

endmodule

[verif/tb_disk_seek_order_scheduler_unit.sv]
// top of the disk seek order scheduler testbench: clock, reset, request and register
// stimulus, result sink and verdict; depends on dso_pkg, dso_seek_monitor and the unit
`timescale 1ns / 1ps
module tb_disk_seek_order_scheduler_unit;
  import dso_pkg::*;

  typedef logic [TRACK_BITS-1:0] track_t;

  localparam int     RANDOM_ITEMS  = 270;
  localparam int     PHASE_ITEMS   = 45;
  localparam int     HOLD_CYCLES   = 600;
  // each result word needs a scan of all held requests, up to 32
  localparam int     SETTLE_CYCLES = 64;
  localparam int     FINAL_CYCLES  = 200;
  localparam int     IDLE_LIMIT    = 20000;
  localparam track_t TRACK_TOP     = '1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  logic                  full;
  req_item_t             req_i       = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  res_item_t             res_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_HEAD_TRACK;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int     fail_count;
  int     pending;
  int     items_sent  = 0;
  int     idle_cycles = 0;
  int     hold_ask    = 0;
  bit     sender_calm = 1'b0;
  track_t cur_head    = '0;

  disk_seek_order_scheduler_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  dso_seek_monitor seek_mon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // tracks cluster around the head and the ends of the disk
  function automatic track_t pick_track(track_t head);
    int r, t;
    r = $urandom_range(0, 99);
    if (r < 10) return head;
    if (r < 25) begin
      t = int'(head) + int'($urandom_range(0, 16)) - 8;
      if (t < 0) t = 0;
      if (t > int'(TRACK_TOP)) t = int'(TRACK_TOP);
      return track_t'(t);
    end
    if (r < 32) return r[0] ? TRACK_TOP : '0;
    return track_t'($urandom_range(0, int'(TRACK_TOP)));
  endfunction

  // small batches mostly, sometimes past the store size
  function automatic int batch_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 16);
    if (r < 98) return $urandom_range(17, MAX_REQUESTS);
    return $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
  endfunction

  // result sink: random stalls, calm stretches, and a long hold on request
  initial begin
    int stall_left;
    int calm_left;
    int roll;
    stall_left = 0;
    calm_left  = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_ask != 0) begin
        stall_left = hold_ask;
        hold_ask   = 0;
        calm_left  = 0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        pop <= 1'b1;
        calm_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) calm_left = $urandom_range(20, 200);
        else if (roll < 40) stall_left = gap_len();
        pop <= (stall_left == 0);
      end
    end
  end

  // both registers, head then mode, in back-to-back cycles; upper mode bits are don't-care
  task automatic set_config(track_t head, mode_e mode, logic [CFG_DATA_W-3:0] junk);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HEAD_TRACK;
    cfg_wdata_i <= head;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_ORDER_MODE;
    cfg_wdata_i <= {junk, mode};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_head     = head;
  endtask

  // one request word, held until accepted
  task automatic offer_request(track_t t, bit is_last);
    int g;
    g = sender_calm ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    push        <= 1'b1;
    req_i.track <= t;
    req_i.last  <= is_last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_batch(int n);
    for (int k = 0; k < n; k++) offer_request(pick_track(cur_head), k == n - 1);
  endtask

  // wait for every expected move, then let the unit settle
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    track_t probe[5] = '{12'd2049, 12'd0, 12'd2048, 12'd4095, 12'd2047};
    int     target;
    int     phase_start;
    track_t head;
    mode_e  mode;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // mid-disk head, both ends and the head itself in every mode
    for (int m = 0; m < 4; m++) begin
      set_config(12'd2048, mode_e'(m), '0);
      foreach (probe[i]) offer_request(probe[i], i == 4);
      drain();
    end
    // single request on the head at track zero
    set_config('0, MODE_CLOOK, '0);
    offer_request('0, 1'b1);
    drain();
    // head at the top end
    set_config(TRACK_TOP, MODE_LOOK, '0);
    offer_request(TRACK_TOP, 1'b0);
    offer_request('0, 1'b1);
    drain();
    set_config('0, MODE_DOWN_SWEEP, '0);
    offer_request(TRACK_TOP, 1'b0);
    offer_request('0, 1'b1);
    drain();

    // store overflow: the dropped request carries last
    set_config(pick_track(12'd2048), MODE_DOWN_SWEEP, '1);
    send_batch(MAX_REQUESTS + 1);
    drain();

    // sink holds off while two batches are offered back to back
    set_config(pick_track(12'd1000), MODE_LOOK, '0);
    hold_ask    = HOLD_CYCLES;
    sender_calm = 1'b1;
    send_batch(12);
    send_batch(10);
    sender_calm = 1'b0;
    drain();

    // random phases, each under its own register setting
    target = items_sent + RANDOM_ITEMS;
    for (int ph = 0; items_sent < target; ph++) begin
      if (ph == 0) head = '0;
      else if (ph == 1) head = TRACK_TOP;
      else head = track_t'($urandom_range(0, int'(TRACK_TOP)));
      mode = (ph < 4) ? mode_e'(ph) : mode_e'($urandom_range(0, 3));
      set_config(head, mode, (CFG_DATA_W-2)'($urandom));
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS && items_sent < target) begin
        sender_calm = ($urandom_range(0, 9) == 0);
        send_batch(batch_size());
      end
      sender_calm = 1'b0;
      drain();
    end

    repeat (FINAL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dso_pkg.sv
rtl/dso_front.sv
rtl/dso_res_fifo.sv
rtl/dso_back.sv
rtl/disk_seek_order_scheduler_unit.sv
verif/dso_seek_monitor.sv
verif/tb_disk_seek_order_scheduler_unit.sv
